// ----- src/rfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_pkg
// Types and constants shared by the frame receiver front end, command queue
// and reply sequencer.
// ----------------------------------------------------------------------------
package rfr_pkg;

	localparam int PAYLOAD_LEN = 9;
	localparam int REPLY_LEN   = 13;
	localparam int PAY_IDX_W   = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
	localparam int SEQ_W       = $clog2(PAYLOAD_LEN + REPLY_LEN);

	localparam logic [7:0] SYNC_A          = 8'hFF;
	localparam logic [7:0] SYNC_B          = 8'hFE;
	localparam logic [7:0] REPLY_LEN_BYTE  = 8'd8;
	localparam logic [7:0] REPLY_TAG       = 8'd120;
	localparam logic [7:0] REPLY_PAD       = 8'd0;
	localparam logic [7:0] DEVICE_ID_RESET = 8'd1;

	// frame position counter codes
	localparam logic [7:0] POS_HUNT   = 8'd0;
	localparam logic [7:0] POS_SYNC_B = 8'd1;
	localparam logic [7:0] POS_ID     = 8'd2;
	localparam logic [7:0] POS_LEN    = 8'd3;
	localparam logic [7:0] POS_DATA   = 8'd4;

	typedef enum logic [1:0] {
		RK_ERROR   = 2'd0,
		RK_PAYLOAD = 2'd1,
		RK_REPLY   = 2'd2
	} result_kind_t;

	// reply byte positions
	localparam logic [3:0] RP_SYNC_A = 4'd0;
	localparam logic [3:0] RP_SYNC_B = 4'd1;
	localparam logic [3:0] RP_ID     = 4'd2;
	localparam logic [3:0] RP_LEN    = 4'd3;
	localparam logic [3:0] RP_BTN0   = 4'd4;
	localparam logic [3:0] RP_BTN1   = 4'd5;
	localparam logic [3:0] RP_CNC0   = 4'd6;
	localparam logic [3:0] RP_CNC1   = 4'd7;
	localparam logic [3:0] RP_FLG0   = 4'd8;
	localparam logic [3:0] RP_FLG1   = 4'd9;
	localparam logic [3:0] RP_BAT    = 4'd10;
	localparam logic [3:0] RP_TAG    = 4'd11;
	localparam logic [3:0] RP_PAD    = 4'd12;

	// one finished frame end, handed from front to back
	typedef struct packed {
		logic                            good;
		logic [PAYLOAD_LEN-1:0][7:0]     payload;
		logic [7:0]                      dev_id;
		logic [7:0]                      btn;
		logic [7:0]                      cnc;
		logic [7:0]                      flg;
		logic [7:0]                      bat;
		logic [15:0]                     err_cnt;
		logic [7:0]                      good_cnt;
		logic                            led;
	} cmd_t;

endpackage

// ----- src/rfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_front
// Frame hunter: tracks sync, id, length and payload, checks the XOR and
// issues one command for every frame end.
// ----------------------------------------------------------------------------
module rfr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [7:0]    cfg_data,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	input  logic [7:0]    button_bits,
	input  logic [7:0]    cancel_bits,
	input  logic [7:0]    input_flags,
	input  logic [7:0]    battery_code,
	output logic          cmd_valid,
	output rfr_pkg::cmd_t cmd
);

	logic [7:0]  dev_id_q;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  end_q, end_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] err_q, err_d;
	logic [7:0]  good_q, good_d;
	logic [1:0]  link_q, link_d;
	logic [rfr_pkg::PAYLOAD_LEN-1:0][7:0] store_q;

	logic [7:0]                    data_off;
	logic [rfr_pkg::PAY_IDX_W-1:0] wr_idx;
	logic                          wr_en;
	logic                          frame_end;
	logic                          good;

	assign data_off = pos_q - rfr_pkg::POS_DATA;
	assign wr_idx   = data_off[rfr_pkg::PAY_IDX_W-1:0];

	always_comb begin
		pos_d     = pos_q;
		end_d     = end_q;
		xor_d     = xor_q;
		err_d     = err_q;
		good_d    = good_q;
		link_d    = link_q;
		wr_en     = 1'b0;
		frame_end = 1'b0;
		good      = 1'b0;
		if (accept) begin
			priority if (pos_q == rfr_pkg::POS_HUNT) begin
				end_d = 8'd0;
				if (rx_byte == rfr_pkg::SYNC_A) begin
					pos_d = rfr_pkg::POS_SYNC_B;
				end
			end else if (pos_q == rfr_pkg::POS_SYNC_B && rx_byte == rfr_pkg::SYNC_B) begin
				end_d = 8'd0;
				pos_d = rfr_pkg::POS_ID;
			end else if (pos_q == rfr_pkg::POS_ID) begin
				if (rx_byte == dev_id_q) begin
					end_d = 8'd0;
					pos_d = rfr_pkg::POS_LEN;
				end else begin
					pos_d = rfr_pkg::POS_HUNT;
				end
			end else if (pos_q == rfr_pkg::POS_LEN) begin
				end_d = rx_byte + rfr_pkg::POS_DATA;
				pos_d = rfr_pkg::POS_DATA;
				xor_d = 8'd0;
			end else if (pos_q > rfr_pkg::POS_LEN && pos_q < end_q) begin
				// bytes past the payload length are counted but not kept
				if (data_off < 8'(rfr_pkg::PAYLOAD_LEN)) begin
					wr_en = 1'b1;
					xor_d = xor_q ^ rx_byte;
				end
				pos_d = pos_q + 8'd1;
			end else begin
				// frame end, or a lost second sync byte
				frame_end = 1'b1;
				good = (pos_q == 8'(rfr_pkg::PAYLOAD_LEN + 4)) &&
					(end_q == 8'(rfr_pkg::PAYLOAD_LEN + 4)) && (rx_byte == xor_q);
				pos_d = rfr_pkg::POS_HUNT;
				end_d = 8'd0;
				if (good) begin
					good_d = good_q + 8'd1;
					link_d = (link_q == 2'd2) ? 2'd0 : link_q + 2'd1;
				end else begin
					err_d = err_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q <= rfr_pkg::DEVICE_ID_RESET;
			pos_q    <= rfr_pkg::POS_HUNT;
			end_q    <= 8'd0;
			xor_q    <= 8'd0;
			err_q    <= 16'd0;
			good_q   <= 8'd0;
			link_q   <= 2'd0;
		end else begin
			if (cfg_write) begin
				dev_id_q <= cfg_data;
			end
			pos_q  <= pos_d;
			end_q  <= end_d;
			xor_q  <= xor_d;
			err_q  <= err_d;
			good_q <= good_d;
			link_q <= link_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < rfr_pkg::PAYLOAD_LEN; i++) begin
			if (wr_en && wr_idx == rfr_pkg::PAY_IDX_W'(i)) begin
				store_q[i] <= rx_byte;
			end
		end
	end

	assign cmd_valid    = frame_end;
	assign cmd.good     = good;
	assign cmd.payload  = store_q;
	assign cmd.dev_id   = dev_id_q;
	assign cmd.btn      = button_bits;
	assign cmd.cnc      = cancel_bits;
	assign cmd.flg      = input_flags;
	assign cmd.bat      = battery_code;
	assign cmd.err_cnt  = err_d;
	assign cmd.good_cnt = good_d;
	assign cmd.led      = (link_d == 2'd2);

endmodule

// ----- src/rfr_cmd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_cmd_queue
// Short register queue of frame-end commands between front and back.
// ----------------------------------------------------------------------------
module rfr_cmd_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enq,
	input  rfr_pkg::cmd_t enq_data,
	output logic          full,
	input  logic          deq,
	output rfr_pkg::cmd_t head,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rfr_pkg::cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_enq, do_deq;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_enq = enq && !full;
	assign do_deq = deq && !empty;
	assign head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_enq, do_deq})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			entry_q[wr_ptr_q] <= enq_data;
		end
	end

endmodule

// ----- src/rfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfr_back
// Result sequencer: walks the head command out as one error beat, or as the
// payload bytes followed by the reply bytes.
// ----------------------------------------------------------------------------
module rfr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rfr_pkg::cmd_t head,
	input  logic          head_empty,
	output logic          head_deq,
	input  logic          pop,
	output logic [1:0]    result_kind,
	output logic [3:0]    byte_index,
	output logic [7:0]    byte_value,
	output logic          last,
	output logic [15:0]   error_count,
	output logic [7:0]    good_count,
	output logic          link_led
);

	logic [rfr_pkg::SEQ_W-1:0] seq_q;
	logic [rfr_pkg::SEQ_W-1:0] rep_off;
	logic [3:0]                rep_idx;
	logic                      in_payload;
	logic                      seq_last;
	logic [7:0]                rep_byte;
	logic                      take;

	assign in_payload = seq_q < rfr_pkg::SEQ_W'(rfr_pkg::PAYLOAD_LEN);
	assign rep_off    = seq_q - rfr_pkg::SEQ_W'(rfr_pkg::PAYLOAD_LEN);
	assign rep_idx    = rep_off[3:0];
	assign seq_last   = seq_q == rfr_pkg::SEQ_W'(rfr_pkg::PAYLOAD_LEN + rfr_pkg::REPLY_LEN - 1);
	assign take       = pop && !head_empty;

	always_comb begin
		unique case (rep_idx)
			rfr_pkg::RP_SYNC_A: rep_byte = rfr_pkg::SYNC_A;
			rfr_pkg::RP_SYNC_B: rep_byte = rfr_pkg::SYNC_B;
			rfr_pkg::RP_ID:     rep_byte = head.dev_id;
			rfr_pkg::RP_LEN:    rep_byte = rfr_pkg::REPLY_LEN_BYTE;
			rfr_pkg::RP_BTN0,
			rfr_pkg::RP_BTN1:   rep_byte = head.btn;
			rfr_pkg::RP_CNC0,
			rfr_pkg::RP_CNC1:   rep_byte = head.cnc;
			rfr_pkg::RP_FLG0,
			rfr_pkg::RP_FLG1:   rep_byte = head.flg;
			rfr_pkg::RP_BAT:    rep_byte = head.bat;
			rfr_pkg::RP_TAG:    rep_byte = rfr_pkg::REPLY_TAG;
			default:            rep_byte = rfr_pkg::REPLY_PAD;
		endcase
	end

	always_comb begin
		if (!head.good) begin
			result_kind = rfr_pkg::RK_ERROR;
			byte_index  = 4'd0;
			byte_value  = 8'd0;
			last        = 1'b1;
		end else if (in_payload) begin
			result_kind = rfr_pkg::RK_PAYLOAD;
			byte_index  = 4'(seq_q);
			byte_value  = head.payload[seq_q[rfr_pkg::PAY_IDX_W-1:0]];
			last        = 1'b0;
		end else begin
			result_kind = rfr_pkg::RK_REPLY;
			byte_index  = rep_idx;
			byte_value  = rep_byte;
			last        = seq_last;
		end
	end

	assign error_count = head.err_cnt;
	assign good_count  = head.good_cnt;
	assign link_led    = head.led;
	assign head_deq    = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (take) begin
			seq_q <= last ? '0 : seq_q + rfr_pkg::SEQ_W'(1);
		end
	end

endmodule

// ----- src/rs485_frame_receiver_responder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_frame_receiver_responder
// Sync / id / length / XOR frame receiver that answers good frames with the
// payload and a fixed reply carrying the button, cancel, flag and battery bytes.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        rx_byte, button_bits, cancel_bits,
//                               input_flags, battery_code
//  result    empty / pop        result_kind, byte_index, byte_value, last,
//                               error_count, good_count, link_led
//  config    cfg_write          cfg_data (device id)
//
//  one input byte per cycle while full is low, each handled in the cycle it is taken
//  a good frame end gives 22 result beats, a bad one gives 1, one beat a cycle
//  from the sequencer while pop is high; frame ends wait in a QUEUE_DEPTH entry queue
//  full rises only while that queue is full, so long pop stalls back up input
//  reset clears position, checksum and counters; device id resets to 1
// ----------------------------------------------------------------------------
module rs485_frame_receiver_responder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  button_bits,
	input  logic [7:0]  cancel_bits,
	input  logic [7:0]  input_flags,
	input  logic [7:0]  battery_code,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [3:0]  byte_index,
	output logic [7:0]  byte_value,
	output logic        last,
	output logic [15:0] error_count,
	output logic [7:0]  good_count,
	output logic        link_led
);

	logic          accept;
	logic          cmd_valid;
	rfr_pkg::cmd_t cmd;
	rfr_pkg::cmd_t head;
	logic          head_deq;

	assign accept = push && !full;

	rfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.button_bits  (button_bits),
		.cancel_bits  (cancel_bits),
		.input_flags  (input_flags),
		.battery_code (battery_code),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	rfr_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (cmd_valid),
		.enq_data (cmd),
		.full     (full),
		.deq      (head_deq),
		.head     (head),
		.empty    (empty)
	);

	rfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_empty  (empty),
		.head_deq    (head_deq),
		.pop         (pop),
		.result_kind (result_kind),
		.byte_index  (byte_index),
		.byte_value  (byte_value),
		.last        (last),
		.error_count (error_count),
		.good_count  (good_count),
		.link_led    (link_led)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the frame receiver with directed and random byte streams.
// Good frames, broken syncs, wrong ids, wrong lengths, bad checksums and
// noise are all sent. A built-in predictor tracks the frame hunt, checksum
// and counters and checks every result beat field by field, with random
// stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import rfr_pkg::*;

	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 400;
	localparam int MAX_REPORTS   = 50;

	typedef struct {
		logic [7:0] rx;
		logic [7:0] btn;
		logic [7:0] cnc;
		logic [7:0] flg;
		logic [7:0] bat;
	} rx_item_t;

	typedef struct {
		result_kind_t kind;
		logic [3:0]   idx;
		logic [7:0]   val;
		logic         last;
		logic [15:0]  err;
		logic [7:0]   good;
		logic         led;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [7:0]  cfg_data;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic [7:0]  button_bits;
	logic [7:0]  cancel_bits;
	logic [7:0]  input_flags;
	logic [7:0]  battery_code;
	logic        empty;
	logic        pop;
	logic [1:0]  result_kind;
	logic [3:0]  byte_index;
	logic [7:0]  byte_value;
	logic        last;
	logic [15:0] error_count;
	logic [7:0]  good_count;
	logic        link_led;

	// predictor state
	logic [7:0]  frame_pos;
	logic [7:0]  frame_end_pos;
	logic [7:0]  data_count;
	logic [7:0]  data_bytes [PAYLOAD_LEN];
	logic [7:0]  data_xor;
	logic [15:0] err_total;
	logic [7:0]  good_total;
	logic [1:0]  link_state;
	logic [7:0]  dev_id;

	beat_t expected_beats [$];
	int    failures;
	int    framed_bytes;
	logic  no_gaps;
	logic  long_hold_req;

	rs485_frame_receiver_responder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.button_bits  (button_bits),
		.cancel_bits  (cancel_bits),
		.input_flags  (input_flags),
		.battery_code (battery_code),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.byte_index   (byte_index),
		.byte_value   (byte_value),
		.last         (last),
		.error_count  (error_count),
		.good_count   (good_count),
		.link_led     (link_led)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic rx_item_t rand_item(input logic [7:0] rx);
		rx_item_t it;
		it.rx  = rx;
		it.btn = 8'($urandom);
		it.cnc = 8'($urandom);
		it.flg = 8'($urandom);
		it.bat = 8'($urandom);
		return it;
	endfunction

	function automatic void add_beat(input result_kind_t kind, input logic [3:0] idx,
			input logic [7:0] val, input logic is_last);
		beat_t b;
		b.kind = kind;
		b.idx  = idx;
		b.val  = val;
		b.last = is_last;
		b.err  = err_total;
		b.good = good_total;
		b.led  = (link_state == 2'd2);
		expected_beats.push_back(b);
	endfunction

	// advances the frame hunt by one byte and queues the beats it causes
	function automatic void predict_frame_byte(input rx_item_t it);
		logic       good;
		logic [7:0] reply [REPLY_LEN];
		if (frame_pos == POS_HUNT) begin
			frame_end_pos = 8'd0;
			if (it.rx == SYNC_A)
				frame_pos = POS_SYNC_B;
			return;
		end
		if (frame_pos == POS_SYNC_B && it.rx == SYNC_B) begin
			frame_end_pos = 8'd0;
			frame_pos = POS_ID;
			return;
		end
		if (frame_pos == POS_ID) begin
			if (it.rx == dev_id) begin
				frame_end_pos = 8'd0;
				frame_pos = POS_LEN;
			end else begin
				frame_pos = POS_HUNT;
			end
			return;
		end
		if (frame_pos == POS_LEN) begin
			frame_end_pos = it.rx + 8'd4;
			frame_pos = POS_DATA;
			data_count = 8'd0;
			data_xor = 8'd0;
			return;
		end
		if (frame_pos >= POS_DATA && frame_pos < frame_end_pos) begin
			if (data_count < PAYLOAD_LEN) begin
				data_bytes[data_count] = it.rx;
				data_xor ^= it.rx;
			end
			data_count++;
			frame_pos++;
			return;
		end

		// frame end, or a lost second sync byte
		good = (frame_pos == frame_end_pos) && (frame_end_pos != 8'd0) &&
			(data_count == PAYLOAD_LEN) && (it.rx == data_xor);
		frame_pos = POS_HUNT;
		frame_end_pos = 8'd0;
		if (!good) begin
			err_total++;
			add_beat(RK_ERROR, 4'd0, 8'd0, 1'b1);
			return;
		end
		good_total++;
		link_state = (link_state == 2'd2) ? 2'd0 : link_state + 2'd1;
		for (int i = 0; i < PAYLOAD_LEN; i++)
			add_beat(RK_PAYLOAD, 4'(i), data_bytes[i], 1'b0);
		reply[RP_SYNC_A] = SYNC_A;
		reply[RP_SYNC_B] = SYNC_B;
		reply[RP_ID]     = dev_id;
		reply[RP_LEN]    = REPLY_LEN_BYTE;
		reply[RP_BTN0]   = it.btn;
		reply[RP_BTN1]   = it.btn;
		reply[RP_CNC0]   = it.cnc;
		reply[RP_CNC1]   = it.cnc;
		reply[RP_FLG0]   = it.flg;
		reply[RP_FLG1]   = it.flg;
		reply[RP_BAT]    = it.bat;
		reply[RP_TAG]    = REPLY_TAG;
		reply[RP_PAD]    = REPLY_PAD;
		for (int i = 0; i < REPLY_LEN; i++)
			add_beat(RK_REPLY, 4'(i), reply[i], i == REPLY_LEN - 1);
	endfunction

	function automatic void check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			failures++;
			// keep the log short when something is badly broken
			if (failures <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_drain
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : beat_checker
		beat_t want;
		if (arst_n && pop && !empty) begin
			if (expected_beats.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: unexpected beat, expected none, actual kind %0h index %0h value %0h",
						$time, result_kind, byte_index, byte_value);
			end else begin
				want = expected_beats.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("byte_index", want.idx, byte_index);
				check_field("byte_value", want.val, byte_value);
				check_field("last", want.last, last);
				check_field("error_count", want.err, error_count);
				check_field("good_count", want.good, good_count);
				check_field("link_led", want.led, link_led);
			end
		end
	end

	task automatic send_byte(input rx_item_t it);
		int gap;
		push         <= 1'b1;
		rx_byte      <= it.rx;
		button_bits  <= it.btn;
		cancel_bits  <= it.cnc;
		input_flags  <= it.flg;
		battery_code <= it.bat;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_frame_byte(it);
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sync, id, length, data bytes, checksum; lengths past 251 wrap the end
	task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
			input logic bad_sum);
		logic [7:0] sum;
		rx_item_t   it;
		int         n;
		sum = 8'h00;
		n = (len > 8'd251) ? 0 : len;
		send_byte(rand_item(SYNC_A));
		send_byte(rand_item(SYNC_B));
		send_byte(rand_item(id));
		send_byte(rand_item(len));
		for (int i = 0; i < n; i++) begin
			it = rand_item(8'($urandom));
			if (i < PAYLOAD_LEN)
				sum ^= it.rx;
			send_byte(it);
		end
		if (bad_sum)
			sum ^= 8'($urandom_range(1, 255));
		send_byte(rand_item(sum));
		framed_bytes += n + 5;
	endtask

	task automatic send_lost_sync();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == SYNC_B);
		send_byte(rand_item(SYNC_A));
		send_byte(rand_item(b));
	endtask

	task automatic send_wrong_id(input logic [7:0] id);
		send_byte(rand_item(SYNC_A));
		send_byte(rand_item(SYNC_B));
		send_byte(rand_item(id));
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_device_id(input logic [7:0] v);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		dev_id = v;
	endtask

	// reset id, data extremes in the payload, side fields at their extremes
	task automatic test_good_frame();
		logic [7:0] pay [PAYLOAD_LEN];
		logic [7:0] sum;
		rx_item_t   tail;
		pay = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFE, 8'h00};
		sum = 8'h00;
		send_byte(rand_item(SYNC_A));
		send_byte(rand_item(SYNC_B));
		send_byte(rand_item(DEVICE_ID_RESET));
		send_byte(rand_item(8'(PAYLOAD_LEN)));
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			sum ^= pay[i];
			send_byte(rand_item(pay[i]));
		end
		tail = '{rx: sum, btn: 8'hFF, cnc: 8'h00, flg: 8'hFF, bat: 8'h00};
		send_byte(tail);
	endtask

	// dropped noise, lost second sync, id mismatch, wrapped length
	task automatic test_broken_frames();
		send_byte(rand_item(8'h00));
		send_lost_sync();
		send_wrong_id(DEVICE_ID_RESET ^ 8'h04);
		send_frame(DEVICE_ID_RESET, 8'hFF, 1'b0);
	endtask

	task automatic test_random_traffic(input logic [7:0] id, input int n_items,
			input logic quiet);
		int         pick;
		int         noise;
		logic [7:0] len;
		write_device_id(id);
		no_gaps = quiet;
		framed_bytes = 0;
		while (framed_bytes < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_frame(dev_id, 8'(PAYLOAD_LEN), 1'b0);
			end else if (pick < 70) begin
				send_frame(dev_id, 8'(PAYLOAD_LEN), 1'b1);
			end else if (pick < 78) begin
				if ($urandom_range(0, 5) == 0) begin
					len = 8'($urandom_range(252, 255));
				end else begin
					len = 8'($urandom_range(0, 19));
					if (len >= PAYLOAD_LEN)
						len++;
				end
				send_frame(dev_id, len, 1'($urandom));
			end else if (pick < 84) begin
				send_wrong_id(dev_id ^ 8'($urandom_range(1, 255)));
				framed_bytes += 3;
			end else if (pick < 90) begin
				send_lost_sync();
				framed_bytes += 2;
			end else begin
				noise = $urandom_range(1, 4);
				repeat (noise) send_byte(rand_item(8'($urandom)));
				framed_bytes += noise;
			end
		end
		no_gaps = 1'b0;
	endtask

	// receiver holds off while frames keep coming, so full has to rise
	task automatic test_backpressure();
		wait_idle();
		long_hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (10) send_frame(dev_id, 8'(PAYLOAD_LEN), 1'b0);
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_data     = 8'h00;
		push         = 1'b0;
		rx_byte      = 8'h00;
		button_bits  = 8'h00;
		cancel_bits  = 8'h00;
		input_flags  = 8'h00;
		battery_code = 8'h00;
		frame_pos     = POS_HUNT;
		frame_end_pos = 8'd0;
		data_count    = 8'd0;
		data_xor      = 8'd0;
		err_total     = 16'd0;
		good_total    = 8'd0;
		link_state    = 2'd0;
		dev_id        = DEVICE_ID_RESET;
		failures      = 0;
		framed_bytes  = 0;
		no_gaps       = 1'b0;
		long_hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_good_frame();
		test_broken_frames();
		test_random_traffic(DEVICE_ID_RESET, 45, 1'b0);
		test_random_traffic(8'h00, 45, 1'b0);
		test_random_traffic(8'hFF, 45, 1'b0);
		test_random_traffic(SYNC_B, 45, 1'b1);
		test_random_traffic(8'($urandom), 45, 1'b0);
		test_backpressure();

		wait_idle();
		if (failures == 0 && expected_beats.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
